// ----- src/rtb_pkg.sv -----
// ----------------------------------------------------------------------------
// rtb_pkg
// Shared types and constants of the rotated texel blitter: item formats,
// register file layout, operation and register codes, default geometry.
// ----------------------------------------------------------------------------
package rtb_pkg;

  // default geometry of source store and world
  localparam int SRC_W_DEF   = 256;
  localparam int SRC_H_DEF   = 256;
  localparam int WORLD_W_DEF = 2048;
  localparam int WORLD_H_DEF = 2048;

  // fraction bits of the coordinate format
  localparam int Q_FRAC = 16;

  // register reset values
  localparam logic signed [17:0] COS_RST  = 18'sh10000;
  localparam logic signed [17:0] SIN_RST  = 18'sh00000;
  localparam logic [8:0]         RECT_RST = 9'd256;
  localparam logic [9:0]         HALF_RST = 10'd128;
  localparam logic signed [12:0] ORG_RST  = 13'sd0;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_MAP  = 1'b1
  } opcode_e;

  typedef enum logic [2:0] {
    REG_COS      = 3'd0,
    REG_SIN      = 3'd1,
    REG_RECT_W   = 3'd2,
    REG_RECT_H   = 3'd3,
    REG_HALF_W   = 3'd4,
    REG_HALF_H   = 3'd5,
    REG_ORIGIN_X = 3'd6,
    REG_ORIGIN_Y = 3'd7
  } cfg_index_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [7:0]  load_x;
    logic [7:0]  load_y;
    logic [7:0]  load_value;
    logic [10:0] box_x;
    logic [10:0] box_y;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [10:0] dest_x;
    logic [10:0] dest_y;
    logic [7:0]  terrain;
  } out_item_t;

  typedef struct packed {
    logic signed [17:0] cos_q16;
    logic signed [17:0] sin_q16;
    logic [8:0]         rect_width;
    logic [8:0]         rect_height;
    logic [9:0]         half_box_w;
    logic [9:0]         half_box_h;
    logic signed [12:0] origin_x;
    logic signed [12:0] origin_y;
  } cfg_t;

  // status of the item in the last address stage
  typedef struct packed {
    logic        valid;
    logic        is_map;
    logic        wr_ok;
    logic        src_ok;
    logic        dest_ok;
    logic [10:0] dest_x;
    logic [10:0] dest_y;
  } stage_st_t;

endpackage

// ----- src/rotated_texel_blit.sv -----
// ----------------------------------------------------------------------------
// rotated_texel_blit
// Rotated nearest-neighbor blit into a world map, texel 0 transparent.
// ----------------------------------------------------------------------------
// Usage:
//   in channel (in_valid_i / in_stall_o, in_item_i): a load item writes one
//   texel into the source store; a map item gives one box position and
//   yields exactly one out item, whose write_valid says whether a world
//   write is due. Load items yield no out item.
//   out channel (out_valid_o / out_stall_i, out_item_o) carries the result.
//   cfg channel (cfg_valid_i / cfg_ready_o) writes the registers and is always
//   ready; the user must use it only while the block is idle; no logic checks.
// Timing:
//   one item per cycle sustained while out_stall_i is low; a map item passes
//   three address stages, the last one issuing the registered store read, and
//   its result shows from the output stage. Rate is set by the single store
//   port, which takes one load write or one map read per cycle, in item order.
// Reset: registers take their defaults and the pipeline empties; the source
//   store holds no defined texels until loaded.
// Stall: empty stages still fill while the out item waits; once all stages
//   hold items, in_stall_o rises and everything holds.
// ----------------------------------------------------------------------------
module rotated_texel_blit import rtb_pkg::*; #(
  parameter int SRC_W   = SRC_W_DEF,
  parameter int SRC_H   = SRC_H_DEF,
  parameter int WORLD_W = WORLD_W_DEF,
  parameter int WORLD_H = WORLD_H_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i
);

  localparam int DEPTH = SRC_W * SRC_H;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cfg_t          cfg;
  stage_st_t     st;
  logic [AW-1:0] ram_addr;
  logic [7:0]    ram_wdata;
  logic [7:0]    ram_rdata;
  logic          out_ready;
  logic          ram_en;

  assign cfg_ready_o = 1'b1;

  rtb_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rtb_addr_pipe #(
    .SRC_W   (SRC_W),
    .SRC_H   (SRC_H),
    .WORLD_W (WORLD_W),
    .WORLD_H (WORLD_H)
  ) u_pipe (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .adv_i       (out_ready),
    .st_o        (st),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata)
  );

  // store access when the last address stage moves on
  assign ram_en = st.valid && out_ready;

  rtb_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (st.wr_ok),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // output stage, aligned with the store read data
  logic        v4_q;
  logic        ok4_q;
  logic [10:0] dx4_q, dy4_q;
  logic        wr_valid;

  assign out_ready = !v4_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (out_ready) begin
      v4_q <= st.valid && st.is_map;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_ready) begin
      ok4_q <= st.src_ok && st.dest_ok;
      dx4_q <= st.dest_x;
      dy4_q <= st.dest_y;
    end
  end

  // transparent texels and rejected positions give an empty write
  assign wr_valid                = ok4_q && (ram_rdata != 8'd0);
  assign out_valid_o             = v4_q;
  assign out_item_o.write_valid  = wr_valid;
  assign out_item_o.dest_x       = wr_valid ? dx4_q : 11'd0;
  assign out_item_o.dest_y       = wr_valid ? dy4_q : 11'd0;
  assign out_item_o.terrain      = wr_valid ? ram_rdata : 8'd0;

endmodule

// ----- src/rtb_ram.sv -----
// ----------------------------------------------------------------------------
// rtb_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module rtb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 65536,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic             we_i,
  input  logic [AW-1:0]    addr_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one access per cycle, read data held while disabled or writing
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- src/rtb_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// rtb_cfg_regs
// Register file of the blitter: rotation, rectangle size, box and origin.
// ----------------------------------------------------------------------------
module rtb_cfg_regs import rtb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [17:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  // decode register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_index_e'(cfg_index_i))
        REG_COS:      cfg_d.cos_q16     = $signed(cfg_data_i);
        REG_SIN:      cfg_d.sin_q16     = $signed(cfg_data_i);
        REG_RECT_W:   cfg_d.rect_width  = cfg_data_i[8:0];
        REG_RECT_H:   cfg_d.rect_height = cfg_data_i[8:0];
        REG_HALF_W:   cfg_d.half_box_w  = cfg_data_i[9:0];
        REG_HALF_H:   cfg_d.half_box_h  = cfg_data_i[9:0];
        REG_ORIGIN_X: cfg_d.origin_x    = $signed(cfg_data_i[12:0]);
        REG_ORIGIN_Y: cfg_d.origin_y    = $signed(cfg_data_i[12:0]);
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cos_q16     <= COS_RST;
      cfg_q.sin_q16     <= SIN_RST;
      cfg_q.rect_width  <= RECT_RST;
      cfg_q.rect_height <= RECT_RST;
      cfg_q.half_box_w  <= HALF_RST;
      cfg_q.half_box_h  <= HALF_RST;
      cfg_q.origin_x    <= ORG_RST;
      cfg_q.origin_y    <= ORG_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- src/rtb_addr_pipe.sv -----
// ----------------------------------------------------------------------------
// rtb_addr_pipe
// Three-stage pipeline from input item to store access: box offsets and
// destination check, rotation products, Q16 sums with rounding, then the
// source bounds check and the store address.
// ----------------------------------------------------------------------------
module rtb_addr_pipe import rtb_pkg::*; #(
  parameter int SRC_W   = SRC_W_DEF,
  parameter int SRC_H   = SRC_H_DEF,
  parameter int WORLD_W = WORLD_W_DEF,
  parameter int WORLD_H = WORLD_H_DEF,
  localparam int AW = (SRC_W * SRC_H > 1) ? $clog2(SRC_W * SRC_H) : 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cfg_t          cfg_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  in_item_t      in_item_i,
  input  logic          adv_i,
  output stage_st_t     st_o,
  output logic [AW-1:0] ram_addr_o,
  output logic [7:0]    ram_wdata_o
);

  localparam logic [13:0] WORLD_W_L = 14'(WORLD_W);
  localparam logic [13:0] WORLD_H_L = 14'(WORLD_H);
  localparam logic [15:0] SRC_W_L   = 16'(SRC_W);
  localparam logic [15:0] SRC_H_L   = 16'(SRC_H);

  // stage valid bits and ready chain
  logic v1_q, v2_q, v3_q;
  logic ready1, ready2, ready3;

  assign ready3     = !v3_q || adv_i;
  assign ready2     = !v2_q || ready3;
  assign ready1     = !v1_q || ready2;
  assign in_stall_o = !ready1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (ready1) v1_q <= in_valid_i;
      if (ready2) v2_q <= v1_q;
      if (ready3) v3_q <= v2_q;
    end
  end

  // stage 1: box offsets, world position, load address
  logic signed [11:0] dbx_d, dcy_d;
  logic signed [13:0] dx_d, dy_d;
  logic               dest_ok_d;
  logic               ld_ok_d;
  logic [AW-1:0]      ld_addr_d;

  always_comb begin
    dbx_d = $signed({1'b0, in_item_i.box_x}) - $signed({2'b0, cfg_i.half_box_w});
    dcy_d = $signed({2'b0, cfg_i.half_box_h}) - $signed({1'b0, in_item_i.box_y});
    dx_d  = $signed({3'b0, in_item_i.box_x}) + $signed({cfg_i.origin_x[12], cfg_i.origin_x})
            - $signed({4'b0, cfg_i.half_box_w});
    dy_d  = $signed({3'b0, in_item_i.box_y}) + $signed({cfg_i.origin_y[12], cfg_i.origin_y})
            - $signed({4'b0, cfg_i.half_box_h});
    dest_ok_d = !dx_d[13] && ($unsigned(dx_d) < WORLD_W_L) &&
                !dy_d[13] && ($unsigned(dy_d) < WORLD_H_L);
    ld_ok_d   = ({8'b0, in_item_i.load_x} < SRC_W_L) && ({8'b0, in_item_i.load_y} < SRC_H_L);
    ld_addr_d = AW'(32'(in_item_i.load_y) * 32'(SRC_W) + 32'(in_item_i.load_x));
  end

  opcode_e            op1_q;
  logic               ld_ok1_q, dest_ok1_q;
  logic [AW-1:0]      ld_addr1_q;
  logic [7:0]         ld_val1_q;
  logic signed [11:0] dbx1_q, dcy1_q;
  logic [10:0]        dx1_q, dy1_q;

  always_ff @(posedge clk_i) begin
    if (ready1) begin
      op1_q      <= in_item_i.opcode;
      ld_ok1_q   <= ld_ok_d;
      ld_addr1_q <= ld_addr_d;
      ld_val1_q  <= in_item_i.load_value;
      dbx1_q     <= dbx_d;
      dcy1_q     <= dcy_d;
      dest_ok1_q <= dest_ok_d;
      dx1_q      <= dx_d[10:0];
      dy1_q      <= dy_d[10:0];
    end
  end

  // stage 2: rotation products
  opcode_e            op2_q;
  logic               ld_ok2_q, dest_ok2_q;
  logic [AW-1:0]      ld_addr2_q;
  logic [7:0]         ld_val2_q;
  logic signed [29:0] p_cx2_q, p_sy2_q, p_sx2_q, p_cy2_q;
  logic [10:0]        dx2_q, dy2_q;

  always_ff @(posedge clk_i) begin
    if (ready2) begin
      op2_q      <= op1_q;
      ld_ok2_q   <= ld_ok1_q;
      ld_addr2_q <= ld_addr1_q;
      ld_val2_q  <= ld_val1_q;
      p_cx2_q    <= $signed(cfg_i.cos_q16) * dbx1_q;
      p_sy2_q    <= $signed(cfg_i.sin_q16) * dcy1_q;
      p_sx2_q    <= $signed(cfg_i.sin_q16) * dbx1_q;
      p_cy2_q    <= $signed(cfg_i.cos_q16) * dcy1_q;
      dest_ok2_q <= dest_ok1_q;
      dx2_q      <= dx1_q;
      dy2_q      <= dy1_q;
    end
  end

  // stage 3: q16 sums; center terms fold into (rect + 1) * half unit,
  // which also carries the round-half-up offset
  logic signed [31:0] base_x, base_y;
  logic signed [31:0] sx_d, sy_d;

  always_comb begin
    base_x = $signed((32'(cfg_i.rect_width) + 32'd1) << (Q_FRAC - 1));
    base_y = $signed((32'(cfg_i.rect_height) + 32'd1) << (Q_FRAC - 1));
    sx_d   = base_x + {{2{p_cx2_q[29]}}, p_cx2_q} + {{2{p_sy2_q[29]}}, p_sy2_q};
    sy_d   = base_y + {{2{p_sx2_q[29]}}, p_sx2_q} - {{2{p_cy2_q[29]}}, p_cy2_q};
  end

  opcode_e            op3_q;
  logic               ld_ok3_q, dest_ok3_q;
  logic [AW-1:0]      ld_addr3_q;
  logic [7:0]         ld_val3_q;
  logic signed [31:0] sx3_q, sy3_q;
  logic [10:0]        dx3_q, dy3_q;

  always_ff @(posedge clk_i) begin
    if (ready3) begin
      op3_q      <= op2_q;
      ld_ok3_q   <= ld_ok2_q;
      ld_addr3_q <= ld_addr2_q;
      ld_val3_q  <= ld_val2_q;
      sx3_q      <= sx_d;
      sy3_q      <= sy_d;
      dest_ok3_q <= dest_ok2_q;
      dx3_q      <= dx2_q;
      dy3_q      <= dy2_q;
    end
  end

  // floor of q16 value, bounds check, store address
  logic [15:0]   tx, ty;
  logic          src_ok;
  logic [AW-1:0] map_addr;

  always_comb begin
    tx     = sx3_q[31:Q_FRAC];
    ty     = sy3_q[31:Q_FRAC];
    src_ok = !tx[15] && (tx < {7'b0, cfg_i.rect_width}) && (tx < SRC_W_L) &&
             !ty[15] && (ty < {7'b0, cfg_i.rect_height}) && (ty < SRC_H_L);
    map_addr = AW'(32'(ty[9:0]) * 32'(SRC_W) + 32'(tx[9:0]));
  end

  always_comb begin
    st_o.valid   = v3_q;
    st_o.is_map  = (op3_q == OP_MAP);
    st_o.wr_ok   = (op3_q == OP_LOAD) && ld_ok3_q;
    st_o.src_ok  = src_ok;
    st_o.dest_ok = dest_ok3_q;
    st_o.dest_x  = dx3_q;
    st_o.dest_y  = dy3_q;
  end

  assign ram_addr_o  = (op3_q == OP_MAP) ? map_addr : ld_addr3_q;
  assign ram_wdata_o = ld_val3_q;

endmodule

// ----- src/rtb_checker.sv -----
// ----------------------------------------------------------------------------
// rtb_checker
// Port-level checks of the blitter, bound to the top level.
// ----------------------------------------------------------------------------
module rtb_checker import rtb_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_item_o
);

  // a stalled out item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out item dropped while stalled");

  // a real write never carries a transparent texel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.write_valid |-> out_item_o.terrain != 8'd0)
    else $error("write with zero terrain");

  // an empty write has all fields cleared
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.write_valid |->
      out_item_o.dest_x == 11'd0 && out_item_o.dest_y == 11'd0 &&
      out_item_o.terrain == 8'd0)
    else $error("empty write with nonzero fields");

  // input only backs up when a result waits at the output
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with output empty");

endmodule

bind rotated_texel_blit rtb_checker u_checker (.*);
